// File: design/pofp_pkg.sv
// shared types, codes and reset values for the pulse oximeter frame parser
`timescale 1ns / 1ps

package pofp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned RATE_W = 9;
	localparam int unsigned IDX_W  = 3;

	// configuration register indexes
	localparam logic [IDX_W-1:0] CFG_STALE_SECONDS = 3'd0;
	localparam logic [IDX_W-1:0] CFG_SPO2_FLOOR    = 3'd1;
	localparam logic [IDX_W-1:0] CFG_SPO2_CEILING  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_RATE_FLOOR    = 3'd3;
	localparam logic [IDX_W-1:0] CFG_RATE_CEILING  = 3'd4;

	// configuration reset values
	localparam logic [BYTE_W-1:0] RST_STALE_SECONDS = 8'd5;
	localparam logic [BYTE_W-1:0] RST_SPO2_FLOOR    = 8'd80;
	localparam logic [BYTE_W-1:0] RST_SPO2_CEILING  = 8'd100;
	localparam logic [RATE_W-1:0] RST_RATE_FLOOR    = 9'd50;
	localparam logic [RATE_W-1:0] RST_RATE_CEILING  = 9'd200;

	// frame constants
	localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'h01;
	localparam logic [BYTE_W-1:0] STAT_MASK    = 8'h81;
	localparam logic [BYTE_W-1:0] STAT_RESTART = 8'h81;
	localparam logic [BYTE_W-1:0] STAT_ADVANCE = 8'h80;
	localparam logic [BYTE_W-1:0] IDLE_MAX     = 8'd255;

	// heart rate values that the sensor uses as markers
	localparam logic [RATE_W-1:0] RATE_SENTINEL_A = 9'd511;
	localparam logic [RATE_W-1:0] RATE_SENTINEL_B = 9'd127;
	localparam logic [RATE_W-1:0] RATE_SENTINEL_C = 9'd128;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		POS_SYNC  = 3'd0,
		POS_STAT  = 3'd1,
		POS_PLETH = 3'd2,
		POS_DATA  = 3'd3,
		POS_CHK   = 3'd4
	} pos_t;

	typedef enum logic [1:0] {
		MODE_RATE_HIGH = 2'd0,
		MODE_RATE_LOW  = 2'd1,
		MODE_OXYGEN    = 2'd2,
		MODE_IGNORED   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0] stale_seconds;
		logic [BYTE_W-1:0] spo2_floor;
		logic [BYTE_W-1:0] spo2_ceiling;
		logic [RATE_W-1:0] rate_floor;
		logic [RATE_W-1:0] rate_ceiling;
	} cfg_t;

	typedef struct packed {
		logic [RATE_W-1:0] heart_rate;
		logic [BYTE_W-1:0] oxygen_level;
		logic              rate_updated;
		logic              oxygen_updated;
		logic              checksum_bad;
		logic              values_cleared;
	} result_t;

endpackage

// File: design/pofp_cfg.sv
// configuration register bank
`timescale 1ns / 1ps

module pofp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pofp_pkg::IDX_W-1:0]        cfg_index,
	input  logic [pofp_pkg::RATE_W-1:0]       cfg_data,
	output pofp_pkg::cfg_t                    cfg
);

	pofp_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg        = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stale_seconds <= pofp_pkg::RST_STALE_SECONDS;
			cfg_q.spo2_floor    <= pofp_pkg::RST_SPO2_FLOOR;
			cfg_q.spo2_ceiling  <= pofp_pkg::RST_SPO2_CEILING;
			cfg_q.rate_floor    <= pofp_pkg::RST_RATE_FLOOR;
			cfg_q.rate_ceiling  <= pofp_pkg::RST_RATE_CEILING;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pofp_pkg::CFG_STALE_SECONDS: begin
					cfg_q.stale_seconds <= cfg_data[pofp_pkg::BYTE_W-1:0];
				end
				pofp_pkg::CFG_SPO2_FLOOR: begin
					cfg_q.spo2_floor <= cfg_data[pofp_pkg::BYTE_W-1:0];
				end
				pofp_pkg::CFG_SPO2_CEILING: begin
					cfg_q.spo2_ceiling <= cfg_data[pofp_pkg::BYTE_W-1:0];
				end
				pofp_pkg::CFG_RATE_FLOOR: begin
					cfg_q.rate_floor <= cfg_data;
				end
				pofp_pkg::CFG_RATE_CEILING: begin
					cfg_q.rate_ceiling <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/pofp_core.sv
// input stage, frame state and the per-item parse step
`timescale 1ns / 1ps

module pofp_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        operation,
	input  logic [pofp_pkg::BYTE_W-1:0] rx_byte,
	input  pofp_pkg::cfg_t              cfg,
	input  logic                        adv,
	output logic                        load,
	output pofp_pkg::result_t           res
);

	logic                        valid_s1;
	logic                        op_s1;
	logic [pofp_pkg::BYTE_W-1:0] byte_s1;

	pofp_pkg::pos_t              pos_q, pos_d;
	pofp_pkg::mode_t             mode_q, mode_d;
	logic [pofp_pkg::BYTE_W-1:0] sum_q, sum_d;
	logic [pofp_pkg::RATE_W-1:0] pend_rate_q, pend_rate_d;
	logic [pofp_pkg::BYTE_W-1:0] pend_oxy_q, pend_oxy_d;
	logic [pofp_pkg::RATE_W-1:0] held_rate_q, held_rate_d;
	logic [pofp_pkg::BYTE_W-1:0] held_oxy_q, held_oxy_d;
	logic [pofp_pkg::BYTE_W-1:0] idle_q, idle_d, idle_inc;
	logic                        r_upd, o_upd, bad, cleared;
	logic [pofp_pkg::BYTE_W-1:0] sum_add;
	logic [pofp_pkg::BYTE_W-1:0] stat_bits;
	logic                        rate_ok, oxy_ok;

	assign load     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
	end

	assign sum_add   = sum_q + byte_s1;
	assign stat_bits = byte_s1 & pofp_pkg::STAT_MASK;
	assign idle_inc  = (idle_q == pofp_pkg::IDLE_MAX) ? idle_q : idle_q + 8'd1;

	assign oxy_ok = (pend_oxy_q < cfg.spo2_ceiling) && (pend_oxy_q > cfg.spo2_floor);
	assign rate_ok = (pend_rate_q != pofp_pkg::RATE_SENTINEL_A)
		&& (pend_rate_q != pofp_pkg::RATE_SENTINEL_B)
		&& (pend_rate_q != pofp_pkg::RATE_SENTINEL_C)
		&& (pend_rate_q < cfg.rate_ceiling) && (pend_rate_q > cfg.rate_floor);

	always_comb begin
		pos_d       = pos_q;
		mode_d      = mode_q;
		sum_d       = sum_q;
		pend_rate_d = pend_rate_q;
		pend_oxy_d  = pend_oxy_q;
		held_rate_d = held_rate_q;
		held_oxy_d  = held_oxy_q;
		idle_d      = idle_q;
		r_upd       = 1'b0;
		o_upd       = 1'b0;
		bad         = 1'b0;
		cleared     = 1'b0;
		if (op_s1 == pofp_pkg::OP_TICK) begin
			idle_d = idle_inc;
			if (idle_inc > cfg.stale_seconds) begin
				held_rate_d = '0;
				held_oxy_d  = '0;
				cleared     = 1'b1;
			end
		end else begin
			case (pos_q)
				pofp_pkg::POS_STAT: begin
					sum_d = sum_add;
					if (stat_bits == pofp_pkg::STAT_RESTART) begin
						mode_d = pofp_pkg::MODE_RATE_HIGH;
						pos_d  = pofp_pkg::POS_PLETH;
					end else if (stat_bits == pofp_pkg::STAT_ADVANCE) begin
						// advance saturates at the ignored mode
						if (mode_q != pofp_pkg::MODE_IGNORED) begin
							mode_d = pofp_pkg::mode_t'(mode_q + 2'd1);
						end
						pos_d = pofp_pkg::POS_PLETH;
					end else begin
						pos_d = pofp_pkg::POS_SYNC;
					end
				end
				pofp_pkg::POS_PLETH: begin
					sum_d = sum_add;
					pos_d = pofp_pkg::POS_DATA;
				end
				pofp_pkg::POS_DATA: begin
					sum_d = sum_add;
					case (mode_q)
						pofp_pkg::MODE_RATE_HIGH: begin
							pend_rate_d = {byte_s1[1:0], 7'd0};
						end
						pofp_pkg::MODE_RATE_LOW: begin
							pend_rate_d = {pend_rate_q[8:7], pend_rate_q[6:0] | byte_s1[6:0]};
						end
						pofp_pkg::MODE_OXYGEN: begin
							pend_oxy_d = byte_s1;
						end
						default: begin
						end
					endcase
					pos_d = pofp_pkg::POS_CHK;
				end
				pofp_pkg::POS_CHK: begin
					if (byte_s1 == sum_q) begin
						if (mode_q == pofp_pkg::MODE_OXYGEN && oxy_ok) begin
							held_oxy_d = pend_oxy_q;
							idle_d     = '0;
							o_upd      = 1'b1;
						end else if (mode_q == pofp_pkg::MODE_RATE_LOW && rate_ok) begin
							held_rate_d = pend_rate_q;
							idle_d      = '0;
							r_upd       = 1'b1;
						end
					end else begin
						bad = 1'b1;
					end
					pos_d = pofp_pkg::POS_SYNC;
				end
				default: begin
					pos_d = pofp_pkg::POS_SYNC;
					if (byte_s1 == pofp_pkg::SYNC_BYTE) begin
						sum_d = pofp_pkg::SYNC_BYTE;
						pos_d = pofp_pkg::POS_STAT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= pofp_pkg::POS_SYNC;
			mode_q      <= pofp_pkg::MODE_RATE_HIGH;
			sum_q       <= '0;
			pend_rate_q <= '0;
			pend_oxy_q  <= '0;
			held_rate_q <= '0;
			held_oxy_q  <= '0;
			idle_q      <= '0;
		end else if (load) begin
			pos_q       <= pos_d;
			mode_q      <= mode_d;
			sum_q       <= sum_d;
			pend_rate_q <= pend_rate_d;
			pend_oxy_q  <= pend_oxy_d;
			held_rate_q <= held_rate_d;
			held_oxy_q  <= held_oxy_d;
			idle_q      <= idle_d;
		end
	end

	assign res.heart_rate     = held_rate_d;
	assign res.oxygen_level   = held_oxy_d;
	assign res.rate_updated   = r_upd;
	assign res.oxygen_updated = o_upd;
	assign res.checksum_bad   = bad;
	assign res.values_cleared = cleared;

	a_commit_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load && (r_upd || o_upd) |=> idle_q == '0)
		else $error("commit did not reset idle counter");

	a_tick_keeps_frame: assert property (@(posedge clk) disable iff (!arst_n)
		load && op_s1 == pofp_pkg::OP_TICK |=> $stable(pos_q) && $stable(sum_q))
		else $error("tick disturbed frame state");

	a_bad_back_to_sync: assert property (@(posedge clk) disable iff (!arst_n)
		load && bad |=> pos_q == pofp_pkg::POS_SYNC)
		else $error("bad checksum did not return to sync");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> $onehot0({r_upd, o_upd, bad, cleared}))
		else $error("more than one result flag set");

	a_cleared_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		load && cleared |=> held_rate_q == '0 && held_oxy_q == '0)
		else $error("clear left a held value");

endmodule

// File: design/pofp_out.sv
// result register toward the receiver
`timescale 1ns / 1ps

module pofp_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  pofp_pkg::result_t res,
	output logic              adv,
	output logic              out_valid,
	input  logic              out_stall,
	output pofp_pkg::result_t res_out
);

	logic              out_valid_q;
	pofp_pkg::result_t res_q;

	// the register can take a new item when empty or being emptied
	assign adv       = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// File: design/pulse_oximeter_frame_parser.sv
// top level of the pulse oximeter serial frame parser
//
// input channel: in_valid / in_stall with operation (0 byte, 1 one-second tick)
// and rx_byte. an item is taken on a clock edge with in_valid high and
// in_stall low. every item gives exactly one result on the output channel:
// out_valid / out_stall with the held heart rate and SpO2 and four flags.
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, writes are registered and index values past the last
// register are dropped. write only while no item is in flight.
// an accepted item waits in the input stage until the parse step moves it into the
// result register, which drives out_valid. one item per cycle is taken unless the
// receiver stalls; the frame state updates once per item.
// reset (arst_n low) returns to waiting for sync, rate-high mode, all held
// values and the idle counter to zero, and the registers to their defaults.
// when the receiver stalls, the result register holds and one more item can
// sit in the input stage; in_stall rises only when both are full.
`timescale 1ns / 1ps

module pulse_oximeter_frame_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        operation,
	input  logic [pofp_pkg::BYTE_W-1:0] rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pofp_pkg::RATE_W-1:0] heart_rate,
	output logic [pofp_pkg::BYTE_W-1:0] oxygen_level,
	output logic                        rate_updated,
	output logic                        oxygen_updated,
	output logic                        checksum_bad,
	output logic                        values_cleared,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pofp_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pofp_pkg::RATE_W-1:0] cfg_data
);

	pofp_pkg::cfg_t    cfg;
	pofp_pkg::result_t res;
	pofp_pkg::result_t res_out;
	logic              adv;
	logic              load;

	pofp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pofp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.rx_byte   (rx_byte),
		.cfg       (cfg),
		.adv       (adv),
		.load      (load),
		.res       (res)
	);

	pofp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign heart_rate     = res_out.heart_rate;
	assign oxygen_level   = res_out.oxygen_level;
	assign rate_updated   = res_out.rate_updated;
	assign oxygen_updated = res_out.oxygen_updated;
	assign checksum_bad   = res_out.checksum_bad;
	assign values_cleared = res_out.values_cleared;

endmodule

// File: verif/pofp_frame_checker.sv
// checker for the pulse oximeter frame parser: predicts each result and compares it
`timescale 1ns / 1ps

module pofp_frame_checker
	import pofp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              operation,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [RATE_W-1:0] heart_rate,
	input  logic [BYTE_W-1:0] oxygen_level,
	input  logic              rate_updated,
	input  logic              oxygen_updated,
	input  logic              checksum_bad,
	input  logic              values_cleared,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [RATE_W-1:0] cfg_data,
	output int                outstanding,
	output int                errors
);

	localparam int SHOW_MAX = 10;

	// register copies
	logic [BYTE_W-1:0] stale_limit;
	logic [BYTE_W-1:0] oxy_floor;
	logic [BYTE_W-1:0] oxy_ceil;
	logic [RATE_W-1:0] bpm_floor;
	logic [RATE_W-1:0] bpm_ceil;

	// parser state
	pos_t              frame_pos;
	mode_t             meas_mode;
	logic [BYTE_W-1:0] chk_sum;
	logic [RATE_W-1:0] rate_acc;
	logic [BYTE_W-1:0] oxy_acc;
	logic [RATE_W-1:0] rate_held;
	logic [BYTE_W-1:0] oxy_held;
	logic [BYTE_W-1:0] idle_secs;

	result_t predicted_readings[$];
	int      shown;

	function automatic result_t parse_item(logic op, logic [BYTE_W-1:0] b);
		result_t r;
		r = '0;
		if (op == OP_TICK) begin
			if (idle_secs != IDLE_MAX)
				idle_secs = idle_secs + 1'b1;
			if (idle_secs > stale_limit) begin
				rate_held = '0;
				oxy_held = '0;
				r.values_cleared = 1'b1;
			end
		end else begin
			case (frame_pos)
				POS_STAT: begin
					chk_sum = chk_sum + b;
					if ((b & STAT_MASK) == STAT_RESTART) begin
						meas_mode = MODE_RATE_HIGH;
						frame_pos = POS_PLETH;
					end else if ((b & STAT_MASK) == STAT_ADVANCE) begin
						if (meas_mode != MODE_IGNORED)
							meas_mode = mode_t'(meas_mode + 2'd1);
						frame_pos = POS_PLETH;
					end else begin
						frame_pos = POS_SYNC;
					end
				end
				POS_PLETH: begin
					chk_sum = chk_sum + b;
					frame_pos = POS_DATA;
				end
				POS_DATA: begin
					chk_sum = chk_sum + b;
					case (meas_mode)
						MODE_RATE_HIGH: rate_acc = {b[1:0], 7'd0};
						MODE_RATE_LOW:  rate_acc = rate_acc | {2'd0, b[6:0]};
						MODE_OXYGEN:    oxy_acc = b;
						default:        ;
					endcase
					frame_pos = POS_CHK;
				end
				POS_CHK: begin
					if (b == chk_sum) begin
						if (meas_mode == MODE_OXYGEN) begin
							if (oxy_acc < oxy_ceil && oxy_acc > oxy_floor) begin
								oxy_held = oxy_acc;
								idle_secs = '0;
								r.oxygen_updated = 1'b1;
							end
						end else if (meas_mode == MODE_RATE_LOW) begin
							// marker values from the sensor are never taken as a rate
							if (rate_acc != RATE_SENTINEL_A && rate_acc != RATE_SENTINEL_B &&
									rate_acc != RATE_SENTINEL_C && rate_acc < bpm_ceil &&
									rate_acc > bpm_floor) begin
								rate_held = rate_acc;
								idle_secs = '0;
								r.rate_updated = 1'b1;
							end
						end
					end else begin
						r.checksum_bad = 1'b1;
					end
					frame_pos = POS_SYNC;
				end
				default: begin
					frame_pos = POS_SYNC;
					if (b == SYNC_BYTE) begin
						chk_sum = SYNC_BYTE;
						frame_pos = POS_STAT;
					end
				end
			endcase
		end
		r.heart_rate = rate_held;
		r.oxygen_level = oxy_held;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			stale_limit <= RST_STALE_SECONDS;
			oxy_floor   <= RST_SPO2_FLOOR;
			oxy_ceil    <= RST_SPO2_CEILING;
			bpm_floor   <= RST_RATE_FLOOR;
			bpm_ceil    <= RST_RATE_CEILING;
			frame_pos = POS_SYNC;
			meas_mode = MODE_RATE_HIGH;
			chk_sum = '0;
			rate_acc = '0;
			oxy_acc = '0;
			rate_held = '0;
			oxy_held = '0;
			idle_secs = '0;
			predicted_readings.delete();
			outstanding <= 0;
			errors <= 0;
			shown = 0;
		end else begin
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
				case (cfg_index)
					CFG_STALE_SECONDS: stale_limit <= cfg_data[BYTE_W-1:0];
					CFG_SPO2_FLOOR:    oxy_floor   <= cfg_data[BYTE_W-1:0];
					CFG_SPO2_CEILING:  oxy_ceil    <= cfg_data[BYTE_W-1:0];
					CFG_RATE_FLOOR:    bpm_floor   <= cfg_data;
					CFG_RATE_CEILING:  bpm_ceil    <= cfg_data;
					default:           ;
				endcase
			end

			// results leave before the new item enters, so pop first
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got = {heart_rate, oxygen_level, rate_updated, oxygen_updated,
					checksum_bad, values_cleared};
				if (predicted_readings.size() == 0) begin
					errors <= errors + 1;
					if (shown < SHOW_MAX)
						$display("%0t: unexpected result item rate=%0d spo2=%0d", $realtime,
							heart_rate, oxygen_level);
					shown++;
				end else begin
					want = predicted_readings.pop_front();
					if (got.heart_rate !== want.heart_rate ||
							got.oxygen_level !== want.oxygen_level ||
							got.rate_updated !== want.rate_updated ||
							got.oxygen_updated !== want.oxygen_updated ||
							got.checksum_bad !== want.checksum_bad ||
							got.values_cleared !== want.values_cleared) begin
						errors <= errors + 1;
						if (shown < SHOW_MAX)
							$display({"%0t: mismatch expected rate=%0d spo2=%0d r/o/bad/clr=%b%b%b%b",
								" got rate=%0d spo2=%0d r/o/bad/clr=%b%b%b%b"}, $realtime,
								want.heart_rate, want.oxygen_level, want.rate_updated,
								want.oxygen_updated, want.checksum_bad, want.values_cleared,
								got.heart_rate, got.oxygen_level, got.rate_updated,
								got.oxygen_updated, got.checksum_bad, got.values_cleared);
						shown++;
					end
				end
			end

			if (in_valid === 1'b1 && in_stall === 1'b0)
				predicted_readings.push_back(parse_item(operation, rx_byte));

			outstanding <= predicted_readings.size();
		end
	end

endmodule

// File: verif/pulse_oximeter_frame_parser_tb.sv
// stimulus and verdict for the pulse oximeter frame parser
`timescale 1ns / 1ps

module pulse_oximeter_frame_parser_tb;
	import pofp_pkg::*;

	localparam real HALF_PERIOD = 6.0;
	localparam int  HOLD_CYCLES = 80;
	localparam int  DRAIN_LIMIT = 5000;
	localparam logic [IDX_W-1:0] CFG_PAST_LAST = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              operation = OP_BYTE;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [RATE_W-1:0] heart_rate;
	logic [BYTE_W-1:0] oxygen_level;
	logic              rate_updated;
	logic              oxygen_updated;
	logic              checksum_bad;
	logic              values_cleared;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [RATE_W-1:0] cfg_data = '0;

	int outstanding;
	int errors;
	int items_sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;

	always #(HALF_PERIOD) clk = ~clk;

	pulse_oximeter_frame_parser dut (.*);

	pofp_frame_checker checker_i (.*);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				n = gap_len();
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
		int n;
		if ($urandom_range(0, 99) < idle_pct) begin
			n = gap_len();
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_tick();
		send_item(OP_TICK, BYTE_W'($urandom));
	endtask

	task automatic send_frame(input logic [7:0] stat, input logic [7:0] pleth,
			input logic [7:0] data, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] bytes[5];
		sum = SYNC_BYTE + stat + pleth + data;
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		bytes = '{SYNC_BYTE, stat, pleth, data, sum};
		foreach (bytes[i]) begin
			// a tick now and then inside a frame must not disturb parsing
			if (i > 0 && $urandom_range(0, 39) == 0)
				send_tick();
			send_item(OP_BYTE, bytes[i]);
		end
	endtask

	function automatic logic [7:0] restart_status();
		return {1'b1, 6'($urandom), 1'b1};
	endfunction

	function automatic logic [7:0] advance_status();
		return {1'b1, 6'($urandom), 1'b0};
	endfunction

	function automatic bit bad_sum();
		return $urandom_range(0, 99) < 8;
	endfunction

	// one full pass: rate high bits, rate low bits, SpO2, sometimes past it
	task automatic send_measurement();
		logic [RATE_W-1:0] bpm;
		logic [7:0]        spo2;
		int                pick;
		int                extra;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			bpm = 9'($urandom_range(40, 210));
		else if (pick < 80)
			case ($urandom_range(0, 2))
				0:       bpm = RATE_SENTINEL_A;
				1:       bpm = RATE_SENTINEL_B;
				default: bpm = RATE_SENTINEL_C;
			endcase
		else
			bpm = 9'($urandom_range(0, 511));
		spo2 = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(75, 100)) : 8'($urandom);
		send_frame(restart_status(), 8'($urandom), {6'($urandom), bpm[8:7]}, bad_sum());
		send_frame(advance_status(), 8'($urandom), {1'($urandom), bpm[6:0]}, bad_sum());
		send_frame(advance_status(), 8'($urandom), spo2, bad_sum());
		if ($urandom_range(0, 3) == 0) begin
			extra = $urandom_range(1, 2);
			repeat (extra)
				send_frame(advance_status(), 8'($urandom), 8'($urandom), bad_sum());
		end
	endtask

	task automatic random_traffic(input int count);
		int stop_at;
		int pick;
		int n;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_measurement();
			end else if (pick < 85) begin
				n = $urandom_range(1, 8);
				repeat (n) send_tick();
			end else if (pick < 93) begin
				// frame cut short or with a status that drops it
				send_item(OP_BYTE, SYNC_BYTE);
				send_item(OP_BYTE, 8'($urandom));
				if ($urandom_range(0, 1) == 1)
					send_item(OP_BYTE, 8'($urandom));
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_item(OP_BYTE, 8'($urandom));
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
	endtask

	// 8-bit registers get a random top bit, which the block must drop
	task automatic apply_settings(input logic [7:0] stale, input logic [7:0] sfloor,
			input logic [7:0] sceil, input logic [8:0] rfloor, input logic [8:0] rceil);
		write_reg(CFG_PAST_LAST, 9'($urandom));
		write_reg(CFG_STALE_SECONDS, {1'($urandom), stale});
		write_reg(CFG_SPO2_FLOOR, {1'($urandom), sfloor});
		write_reg(CFG_SPO2_CEILING, {1'($urandom), sceil});
		write_reg(CFG_RATE_FLOOR, rfloor);
		write_reg(CFG_RATE_CEILING, rceil);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full measurement pass at reset settings, then odd cases
		idle_pct = 0;
		stall_pct = 0;
		send_frame(8'hFF, 8'hFF, 8'h00, 1'b0);
		send_frame(8'h80, 8'h00, 8'hC8, 1'b0);
		send_frame(8'hFE, 8'h5A, 8'h61, 1'b0);
		send_frame(8'h80, 8'hA5, 8'hFF, 1'b1);
		send_item(OP_BYTE, SYNC_BYTE);
		send_item(OP_BYTE, 8'h7F);
		repeat (3) send_tick();

		idle_pct = 20;
		stall_pct = 25;
		random_traffic(230);
		drain();

		// widest ranges, so markers and zero are the only rates turned away
		apply_settings(8'd0, 8'd0, 8'd255, 9'd0, 9'd511);
		idle_pct = 0;
		hold_req = 1'b1;
		random_traffic(60);
		idle_pct = 20;
		random_traffic(200);
		drain();

		// nothing can pass and values never go stale
		apply_settings(8'd255, 8'd254, 8'd255, 9'd511, 9'd0);
		random_traffic(150);
		drain();

		apply_settings(8'($urandom_range(0, 12)), 8'($urandom_range(60, 90)),
			8'($urandom_range(95, 255)), 9'($urandom_range(0, 80)),
			9'($urandom_range(150, 511)));
		idle_pct = 35;
		stall_pct = 35;
		random_traffic(250);
		drain();

		apply_settings(8'd3, 8'd70, 8'd100, 9'd30, 9'd250);
		idle_pct = 0;
		stall_pct = 0;
		random_traffic(200);
		idle_pct = 15;
		stall_pct = 20;
		random_traffic(250);

		in_valid <= 1'b0;
		begin : final_wait
			int waited;
			waited = 0;
			@(posedge clk);
			while (outstanding != 0 && waited < DRAIN_LIMIT) begin
				@(posedge clk);
				waited++;
			end
		end
		repeat (8) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("** pulse_oximeter_frame_parser: PASSED **");
		else
			$display("** pulse_oximeter_frame_parser: FAILED **");
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("** pulse_oximeter_frame_parser: FAILED **");
		$finish;
	end

endmodule
